[sv/tlik_pkg.sv]
// ----------------------------------------------------------------------------
// Two-link arm inverse kinematics: shared package
// Types, register indexes, status codes and the back end's arctangent table;
// the item type is shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package tlik_pkg;

   // Fraction bits of the internal angle (degrees).
   localparam int IFRAC     = 20;
   localparam int TAB_LEN   = 24;
   localparam int TAB_IDX_W = 5;
   localparam int CW        = 32;

   // Configuration register indexes.
   localparam logic [2:0] REG_UPPER_LINK  = 3'd0;
   localparam logic [2:0] REG_LOWER_LINK  = 3'd1;
   localparam logic [2:0] REG_GEAR_RATIO  = 3'd2;
   localparam logic [2:0] REG_SHOULDER_OF = 3'd3;
   localparam logic [2:0] REG_ELBOW_OF    = 3'd4;
   localparam logic [2:0] REG_SHOULDER_LM = 3'd5;
   localparam logic [2:0] REG_ELBOW_LM    = 3'd6;

   // Result status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_UNREACH = 2'd1;
   localparam logic [1:0] STATUS_LIMIT   = 2'd2;

   typedef struct packed {
      logic        [11:0] upper_link_length;
      logic        [11:0] lower_link_length;
      logic        [11:0] shoulder_gear_ratio;
      logic signed [11:0] shoulder_zero_offset;
      logic signed [11:0] elbow_zero_offset;
      logic        [13:0] shoulder_limit;
      logic        [13:0] elbow_limit;
   } cfg_type;

   // One classified item as it travels from the front end to the back end.
   typedef struct packed {
      logic signed [13:0] x;
      logic signed [13:0] y;
      logic signed [28:0] n;      // d2 - A*A - B*B
      logic signed [28:0] m;      // A*A - B*B + d2
      logic        [24:0] h;      // 2*A*B
      logic               reach;
   } entry_type;

   // atan(2^-i) in degrees with IFRAC fraction bits.
   function automatic logic signed [CW-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
      logic signed [CW-1:0] v;
      case (idx)
         5'd0:    v = 32'sd47185920;
         5'd1:    v = 32'sd27855475;
         5'd2:    v = 32'sd14718068;
         5'd3:    v = 32'sd7471121;
         5'd4:    v = 32'sd3750058;
         5'd5:    v = 32'sd1876857;
         5'd6:    v = 32'sd938658;
         5'd7:    v = 32'sd469357;
         5'd8:    v = 32'sd234682;
         5'd9:    v = 32'sd117342;
         5'd10:   v = 32'sd58671;
         5'd11:   v = 32'sd29335;
         5'd12:   v = 32'sd14668;
         5'd13:   v = 32'sd7334;
         5'd14:   v = 32'sd3667;
         5'd15:   v = 32'sd1833;
         5'd16:   v = 32'sd917;
         5'd17:   v = 32'sd458;
         5'd18:   v = 32'sd229;
         5'd19:   v = 32'sd115;
         5'd20:   v = 32'sd57;
         5'd21:   v = 32'sd29;
         5'd22:   v = 32'sd14;
         5'd23:   v = 32'sd7;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

[sv/tlik_req_if.sv]
// ----------------------------------------------------------------------------
// Target point channel
// Valid/ready channel that carries one target point per item.
// ----------------------------------------------------------------------------
interface tlik_req_if;
   logic               valid;
   logic               ready;
   logic signed [13:0] target_x;
   logic signed [13:0] target_y;

   modport source (output valid, output target_x, output target_y, input ready);
   modport sink (input valid, input target_x, input target_y, output ready);
endinterface

[sv/tlik_rsp_if.sv]
// ----------------------------------------------------------------------------
// Joint command channel
// Valid/ready channel that carries one pair of joint commands per item.
// ----------------------------------------------------------------------------
interface tlik_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] shoulder_angle;
   logic signed [14:0] elbow_angle;
   logic        [1:0]  status;

   modport source (output valid, output shoulder_angle, output elbow_angle,
                   output status, input ready);
   modport sink (input valid, input shoulder_angle, input elbow_angle,
                 input status, output ready);
endinterface

[sv/tlik_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Registers the squares of the target and link lengths, then derives the
// cosine-law terms and the reach test and pushes the item into the queue.
// ----------------------------------------------------------------------------
module tlik_front (
   input  logic                clock,
   input  logic                reset,
   input  tlik_pkg::cfg_type   cfg,
   tlik_req_if.sink            req_chan,
   output logic                push_valid,
   input  logic                push_ready,
   output tlik_pkg::entry_type push_data
);

   logic                     v1_ff, v1_in;
   logic signed [13:0]       x1_ff, y1_ff;
   logic        [26:0]       xx_ff, yy_ff;
   logic        [23:0]       aa_ff, bb_ff, ab_ff;
   logic signed [27:0]       xx_full, yy_full;
   logic                     accept;
   logic        [27:0]       d2;
   logic        [24:0]       sum2;
   logic        [24:0]       h;
   logic        [25:0]       lo, hi;

   assign req_chan.ready = !v1_ff || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign xx_full        = req_chan.target_x * req_chan.target_x;
   assign yy_full        = req_chan.target_y * req_chan.target_y;

   // Stage one: squares and link products.
   always_comb begin
      v1_in = v1_ff;
      if (accept) begin
         v1_in = 1'b1;
      end else if (push_ready) begin
         v1_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      if (accept) begin
         x1_ff <= req_chan.target_x;
         y1_ff <= req_chan.target_y;
         xx_ff <= xx_full[26:0];
         yy_ff <= yy_full[26:0];
         aa_ff <= cfg.upper_link_length * cfg.upper_link_length;
         bb_ff <= cfg.lower_link_length * cfg.lower_link_length;
         ab_ff <= cfg.upper_link_length * cfg.lower_link_length;
      end
   end

   // Classification: distance, cosine-law terms and reach window.
   assign d2   = 28'(xx_ff) + 28'(yy_ff);
   assign sum2 = 25'(aa_ff) + 25'(bb_ff);
   assign h    = {ab_ff, 1'b0};
   assign lo   = 26'(sum2) - 26'(h);
   assign hi   = 26'(sum2) + 26'(h);

   always_comb begin
      push_data.x     = x1_ff;
      push_data.y     = y1_ff;
      push_data.h     = h;
      push_data.n     = $signed(29'(d2)) - $signed(29'(sum2));
      push_data.m     = $signed(29'(d2)) + $signed(29'(aa_ff)) - $signed(29'(bb_ff));
      push_data.reach = !y1_ff[13] && (d2 >= 28'(lo)) && (d2 <= 28'(hi));
   end

   assign push_valid = v1_ff;

endmodule

[sv/tlik_queue.sv]
// ----------------------------------------------------------------------------
// Item queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module tlik_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  tlik_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output tlik_pkg::entry_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tlik_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = cnt_ff != CNT_W'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[sv/tlik_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Square root of the cosine-law term, three CORDIC vectoring lanes, shoulder
// scaling, limit test and the result register.
// ----------------------------------------------------------------------------
module tlik_back #(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  tlik_pkg::cfg_type   cfg,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  tlik_pkg::entry_type pop_data,
   tlik_rsp_if.source          rsp_chan
);

   localparam int CW    = tlik_pkg::CW;
   localparam int SW    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int SH_E  = tlik_pkg::IFRAC - ANGLE_FRAC_BITS;
   localparam int SH_S  = tlik_pkg::IFRAC + 10 - ANGLE_FRAC_BITS;
   localparam logic signed [CW-1:0] E_HALF  = CW'(64'sd1 <<< (SH_E - 1));
   localparam logic signed [44:0]   S_HALF  = 45'(64'sd1 <<< (SH_S - 1));
   localparam logic signed [CW-1:0] DEG_90  = CW'(64'sd90 <<< tlik_pkg::IFRAC);

   typedef enum logic [2:0] {
      IDLE, SQUARE, DIFF, ROOT, PREP, ROTATE, SUM, FINISH
   } state_type;

   state_type            state_ff;
   tlik_pkg::entry_type  ent_ff;
   logic        [49:0]   hh_ff, nn_ff, rem_ff, root_ff, bit_ff;
   logic signed [CW-1:0] cx_ff [3];
   logic signed [CW-1:0] cy_ff [3];
   logic signed [CW-1:0] cz_ff [3];
   logic signed [CW-1:0] cx_in [3];
   logic signed [CW-1:0] cy_in [3];
   logic signed [CW-1:0] cz_in [3];
   logic signed [CW-1:0] px [3];
   logic signed [CW-1:0] py [3];
   logic        [2:0]    zero_ff;
   logic        [SW-1:0] step_ff;
   logic        [1:0]    pass_ff;
   logic signed [CW-1:0] q_ff;
   logic signed [44:0]   prod_ff;
   logic                 rsp_valid_ff;
   logic signed [14:0]   sh_out_ff, el_out_ff;
   logic        [1:0]   st_out_ff;

   logic        [24:0]   n_abs;
   logic        [50:0]   trial;
   logic signed [CW-1:0] atan_val;
   logic signed [44:0]   cs;
   logic signed [CW-1:0] ce;
   logic signed [25:0]   rest_prod;
   logic signed [15:0]   rest_sh;
   logic                 out_free;
   logic                 limit_bad;

   assign pop_ready = (state_ff == IDLE);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.shoulder_angle = sh_out_ff;
   assign rsp_chan.elbow_angle    = el_out_ff;
   assign rsp_chan.status         = st_out_ff;

   // Magnitude of n; within 2AB when the target is reachable.
   assign n_abs = ent_ff.n[28] ? 25'(-ent_ff.n) : 25'(ent_ff.n);
   assign trial = 51'(root_ff) + 51'(bit_ff);

   // Lane inputs: elbow (s, n), target (y, x), shoulder term (s, m).
   always_comb begin
      py[0] = CW'(root_ff[24:0]);
      px[0] = CW'(ent_ff.n);
      py[1] = CW'(ent_ff.y);
      px[1] = CW'(ent_ff.x);
      py[2] = CW'(root_ff[24:0]);
      px[2] = CW'(ent_ff.m);
   end

   // CORDIC lanes: pre-rotation into the right half plane, then one step.
   assign atan_val = tlik_pkg::atan_entry(tlik_pkg::TAB_IDX_W'(step_ff));

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cx_in[i] = cx_ff[i];
         cy_in[i] = cy_ff[i];
         cz_in[i] = cz_ff[i];
         if (state_ff == PREP) begin
            cx_in[i] = px[i];
            cy_in[i] = py[i];
            cz_in[i] = '0;
            if (px[i] < 0) begin
               if (py[i] >= 0) begin
                  cx_in[i] = py[i];
                  cy_in[i] = -px[i];
                  cz_in[i] = DEG_90;
               end else begin
                  cx_in[i] = -py[i];
                  cy_in[i] = px[i];
                  cz_in[i] = -DEG_90;
               end
            end
         end else if (cy_ff[i] > 0) begin
            cx_in[i] = cx_ff[i] + (cy_ff[i] >>> step_ff);
            cy_in[i] = cy_ff[i] - (cx_ff[i] >>> step_ff);
            cz_in[i] = cz_ff[i] + atan_val;
         end else begin
            cx_in[i] = cx_ff[i] - (cy_ff[i] >>> step_ff);
            cy_in[i] = cy_ff[i] + (cx_ff[i] >>> step_ff);
            cz_in[i] = cz_ff[i] - atan_val;
         end
      end
   end

   // Final rounding, rest pose and limit test.
   always_comb begin
      cs        = (prod_ff + S_HALF) >>> SH_S;
      ce        = ((cz_ff[0] + E_HALF) >>> SH_E) + CW'(cfg.elbow_zero_offset);
      rest_prod = cfg.shoulder_zero_offset * $signed({1'b0, cfg.shoulder_gear_ratio})
                  + 26'sd512;
      rest_sh   = 16'(rest_prod >>> 10);
      limit_bad = (cs < -$signed(45'(cfg.shoulder_limit)))
                  || (cs > $signed(45'(cfg.shoulder_limit)))
                  || (ce < 0) || (ce > $signed(CW'(cfg.elbow_limit)));
   end

   // Sequencer, datapath registers and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result loaded in FINISH keeps the valid flag set.
         if (rsp_valid_ff && rsp_chan.ready && !(state_ff == FINISH && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (pop_valid) begin
                  ent_ff   <= pop_data;
                  state_ff <= pop_data.reach ? SQUARE : FINISH;
               end
            end
            SQUARE: begin
               hh_ff    <= 50'(ent_ff.h) * 50'(ent_ff.h);
               nn_ff    <= 50'(n_abs) * 50'(n_abs);
               state_ff <= DIFF;
            end
            DIFF: begin
               rem_ff   <= hh_ff - nn_ff;
               root_ff  <= '0;
               bit_ff   <= 50'd1 << 48;
               state_ff <= ROOT;
            end
            ROOT: begin
               if (51'(rem_ff) >= trial) begin
                  rem_ff  <= 50'(51'(rem_ff) - trial);
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  state_ff <= PREP;
               end
            end
            PREP: begin
               for (int i = 0; i < 3; i++) begin
                  cx_ff[i]   <= cx_in[i];
                  cy_ff[i]   <= cy_in[i];
                  cz_ff[i]   <= cz_in[i];
                  zero_ff[i] <= (px[i] == 0) && (py[i] == 0);
               end
               step_ff  <= '0;
               state_ff <= ROTATE;
            end
            ROTATE: begin
               for (int i = 0; i < 3; i++) begin
                  cx_ff[i] <= cx_in[i];
                  cy_ff[i] <= cy_in[i];
                  cz_ff[i] <= zero_ff[i] ? '0 : cz_in[i];
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == SW'(CORDIC_STEPS - 1)) begin
                  pass_ff  <= 2'd0;
                  state_ff <= SUM;
               end
            end
            SUM: begin
               // First pass forms the shoulder angle, second scales it.
               if (pass_ff == 2'd0) begin
                  q_ff    <= cz_ff[1] - cz_ff[2] - DEG_90
                             + (CW'(cfg.shoulder_zero_offset) <<< SH_E);
                  pass_ff <= 2'd1;
               end else begin
                  prod_ff  <= q_ff * $signed({1'b0, cfg.shoulder_gear_ratio});
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (ent_ff.reach && !limit_bad) begin
                     sh_out_ff <= cs[14:0];
                     el_out_ff <= ce[14:0];
                     st_out_ff <= tlik_pkg::STATUS_OK;
                  end else begin
                     sh_out_ff <= rest_sh[14:0];
                     el_out_ff <= 15'(cfg.elbow_zero_offset);
                     st_out_ff <= ent_ff.reach ? tlik_pkg::STATUS_LIMIT
                                               : tlik_pkg::STATUS_UNREACH;
                  end
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

[sv/two_link_arm_inverse_kinematics.sv]
// ----------------------------------------------------------------------------
// Two-link planar arm inverse kinematics
// Turns a target point into shoulder and elbow joint commands, with a reach
// test, a limit test and a rest pose for rejected targets.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_chan  in         target_x, target_y (1/16 mm)
//  rsp_chan  out        shoulder_angle, elbow_angle, status
//  csr_*     in         write enable, register index, 14-bit data
//
// The front end takes one item per clock while the queue has room.
// A reachable item passes in the back end through the one-bit-per-cycle square
// root and then the shared three-lane CORDIC step; an unreachable item goes
// straight to the result stage. The back end takes no new item until it is idle.
// Reset is synchronous and loads the register defaults.
// A stalled result holds in the output register while new items queue.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics #(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 6,
   parameter int QUEUE_DEPTH     = 4
) (
   input  logic        clock,
   input  logic        reset,
   tlik_req_if.sink    req_chan,
   tlik_rsp_if.source  rsp_chan,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   tlik_pkg::cfg_type   cfg_ff;
   tlik_pkg::entry_type push_data, pop_data;
   logic                push_valid, push_ready, pop_valid, pop_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upper_link_length    <= 12'd2400;
         cfg_ff.lower_link_length    <= 12'd1836;
         cfg_ff.shoulder_gear_ratio  <= 12'd1707;
         cfg_ff.shoulder_zero_offset <= -12'sd175;
         cfg_ff.elbow_zero_offset    <= 12'sd126;
         cfg_ff.shoulder_limit       <= 14'd9602;
         cfg_ff.elbow_limit          <= 14'd9920;
      end else if (csr_wen) begin
         case (csr_index)
            tlik_pkg::REG_UPPER_LINK:  cfg_ff.upper_link_length    <= csr_wdata[11:0];
            tlik_pkg::REG_LOWER_LINK:  cfg_ff.lower_link_length    <= csr_wdata[11:0];
            tlik_pkg::REG_GEAR_RATIO:  cfg_ff.shoulder_gear_ratio  <= csr_wdata[11:0];
            tlik_pkg::REG_SHOULDER_OF: cfg_ff.shoulder_zero_offset <= $signed(csr_wdata[11:0]);
            tlik_pkg::REG_ELBOW_OF:    cfg_ff.elbow_zero_offset    <= $signed(csr_wdata[11:0]);
            tlik_pkg::REG_SHOULDER_LM: cfg_ff.shoulder_limit       <= csr_wdata;
            tlik_pkg::REG_ELBOW_LM:    cfg_ff.elbow_limit          <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   tlik_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tlik_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tlik_back #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Two-link arm inverse kinematics testbench
// Drives target points through the block under several register settings and
// idling patterns, predicts each joint command pair with an independent
// fixed-point model and compares every result item field by field.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS     = 16;
   localparam int AFRAC     = 6;
   localparam int FRAC      = 20;
   localparam int DRAIN_WAIT = 200;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [14:0] shoulder;
      logic [14:0] elbow;
      logic [1:0]  status;
   } joint_cmd_type;

   int          mismatches;
   longint      cycles;

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("mismatch at cycle %0d: %s", cycles, msg);
   endtask

   // Scoreboard: holds the predicted joint commands in order of acceptance.
   class joint_scoreboard;
      joint_cmd_type pending[$];

      function void note_target(joint_cmd_type c);
         pending.push_back(c);
      endfunction

      task check_result(logic [14:0] sh, logic [14:0] el, logic [1:0] st);
         joint_cmd_type e;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result item sh=%0h el=%0h st=%0d",
                                      sh, el, st));
            return;
         end
         e = pending.pop_front();
         if (sh !== e.shoulder)
            report_mismatch($sformatf("shoulder %0h, expected %0h", sh, e.shoulder));
         if (el !== e.elbow)
            report_mismatch($sformatf("elbow %0h, expected %0h", el, e.elbow));
         if (st !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wen;
   logic [2:0]  csr_index;
   logic [13:0] csr_wdata;
   int          send_idle_pct;
   int          recv_stall_pct;

   tlik_req_if req_chan ();
   tlik_rsp_if rsp_chan ();

   two_link_arm_inverse_kinematics dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   joint_scoreboard board = new();

   // Register shadow used by the predictor.
   logic [11:0] upper_len, lower_len, gear_ratio;
   logic signed [11:0] shoulder_ofs, elbow_ofs;
   logic [13:0] shoulder_lim, elbow_lim;

   // Clock generator.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle counter with a run timeout.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("** two_link_arm_inverse_kinematics: FAILED **");
            $finish;
         end
      end
   end

   function automatic longint shift_right(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r, bit_val;
      r = 0;
      bit_val = 64'sd1 <<< 62;
      while (bit_val > v) bit_val = bit_val >>> 2;
      while (bit_val != 0) begin
         if (v >= r + bit_val) begin
            v = v - (r + bit_val);
            r = (r >>> 1) + bit_val;
         end else begin
            r = r >>> 1;
         end
         bit_val = bit_val >>> 2;
      end
      return r;
   endfunction

   function automatic longint arctan_step(int i);
      case (i)
         0: return 47185920;  1: return 27855475; 2: return 14718068;
         3: return 7471121;   4: return 3750058;  5: return 1876857;
         6: return 938658;    7: return 469357;   8: return 234682;
         9: return 117342;   10: return 58671;   11: return 29335;
         12: return 14668;   13: return 7334;    14: return 3667;
         15: return 1833;    16: return 917;     17: return 458;
         18: return 229;     19: return 115;     20: return 57;
         21: return 29;      22: return 14;      default: return 7;
      endcase
   endfunction

   // Vectoring CORDIC in degrees with FRAC fraction bits.
   function automatic longint vector_angle(longint y, longint x);
      longint z, t, nx, ny;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 64'sd90 <<< FRAC;
         end else begin
            x = -y; y = t; z = -(64'sd90 <<< FRAC);
         end
      end
      for (int i = 0; i < STEPS; i++) begin
         if (y > 0) begin
            nx = x + shift_right(y, i); ny = y - shift_right(x, i);
            z += arctan_step(i);
         end else begin
            nx = x - shift_right(y, i); ny = y + shift_right(x, i);
            z -= arctan_step(i);
         end
         x = nx; y = ny;
      end
      return z;
   endfunction

   // Joint commands for one target point.
   function automatic joint_cmd_type solve_joints(logic signed [13:0] tx,
                                                  logic signed [13:0] ty);
      joint_cmd_type c;
      longint x, y, a, b, ratio, soff, eoff, d2, sh, el, n, h, diff, s, e, q, cs, ce;
      logic [1:0] st;
      x = tx; y = ty;
      a = upper_len; b = lower_len; ratio = gear_ratio;
      soff = shoulder_ofs; eoff = elbow_ofs;
      d2 = x * x + y * y;
      sh = shift_right(soff * ratio + 512, 10);
      el = eoff;
      st = tlik_pkg::STATUS_UNREACH;
      if (y >= 0 && d2 >= (a - b) * (a - b) && d2 <= (a + b) * (a + b)) begin
         n = d2 - a * a - b * b;
         h = 2 * a * b;
         diff = h * h - n * n;
         s = int_sqrt(diff > 0 ? diff : 0);
         e = vector_angle(s, n);
         q = vector_angle(y, x) - vector_angle(s, a * a - b * b + d2)
             - (64'sd90 <<< FRAC) + soff * (64'sd1 <<< (FRAC - AFRAC));
         cs = shift_right(q * ratio + (64'sd1 <<< (FRAC + 9 - AFRAC)), FRAC + 10 - AFRAC);
         ce = shift_right(e + (64'sd1 <<< (FRAC - 1 - AFRAC)), FRAC - AFRAC) + eoff;
         if (cs < -longint'(shoulder_lim) || cs > longint'(shoulder_lim) ||
             ce < 0 || ce > longint'(elbow_lim)) begin
            st = tlik_pkg::STATUS_LIMIT;
         end else begin
            st = tlik_pkg::STATUS_OK;
            sh = cs;
            el = ce;
         end
      end
      c.shoulder = sh[14:0];
      c.elbow = el[14:0];
      c.status = st;
      return c;
   endfunction

   // Register write, with the shadow kept in step; write_all drops the enable.
   task automatic write_reg(logic [2:0] idx, logic [13:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         tlik_pkg::REG_UPPER_LINK:  upper_len = val[11:0];
         tlik_pkg::REG_LOWER_LINK:  lower_len = val[11:0];
         tlik_pkg::REG_GEAR_RATIO:  gear_ratio = val[11:0];
         tlik_pkg::REG_SHOULDER_OF: shoulder_ofs = val[11:0];
         tlik_pkg::REG_ELBOW_OF:    elbow_ofs = val[11:0];
         tlik_pkg::REG_SHOULDER_LM: shoulder_lim = val;
         tlik_pkg::REG_ELBOW_LM:    elbow_lim = val;
         default: ;
      endcase
   endtask

   task automatic write_all(int ua, int lb, int gr, int so, int eo, int sl, int el);
      write_reg(tlik_pkg::REG_UPPER_LINK, 14'(ua));
      write_reg(tlik_pkg::REG_LOWER_LINK, 14'(lb));
      write_reg(tlik_pkg::REG_GEAR_RATIO, 14'(gr));
      write_reg(tlik_pkg::REG_SHOULDER_OF, 14'(so));
      write_reg(tlik_pkg::REG_ELBOW_OF, 14'(eo));
      write_reg(tlik_pkg::REG_SHOULDER_LM, 14'(sl));
      write_reg(tlik_pkg::REG_ELBOW_LM, 14'(el));
      csr_wen <= 1'b0;
   endtask

   // Send one target point; valid stays high across back-to-back items.
   task automatic send_target(logic signed [13:0] tx, logic signed [13:0] ty);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.target_x <= tx;
      req_chan.target_y <= ty;
      do @(posedge clock); while (!req_chan.ready);
      board.note_target(solve_joints(tx, ty));
   endtask

   task automatic end_burst();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Random point: mostly inside the reach annulus with y >= 0, some anywhere.
   task automatic send_random_target();
      longint a, b, r_lo, r_hi, r, tx, ty;
      int ang;
      real rad;
      a = upper_len; b = lower_len;
      r_lo = (a > b) ? a - b : b - a;
      r_hi = a + b;
      if ($urandom_range(99, 0) < 75 && r_lo < 8000) begin
         if (r_hi > 8000) r_hi = 8000;
         r = $urandom_range(32'(r_hi), 32'(r_lo));
         ang = $urandom_range(1800, 0);
         rad = ang * 3.14159265 / 1800.0;
         tx = longint'(r * $cos(rad)); ty = longint'(r * $sin(rad));
         if (ty < 0) ty = 0;
         send_target(tx[13:0], ty[13:0]);
      end else begin
         send_target(14'($urandom()), 14'($urandom()));
      end
   endtask

   // Result side: random stalls and checks.
   initial begin
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_result(rsp_chan.shoulder_angle, rsp_chan.elbow_angle,
                               rsp_chan.status);
         rsp_chan.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
      end
   end

   // Main sequence.
   initial begin
      int phase;
      reset = 1'b1;
      csr_wen = 1'b0; csr_index = '0; csr_wdata = '0;
      req_chan.valid = 1'b0; req_chan.target_x = '0; req_chan.target_y = '0;
      send_idle_pct = 0; recv_stall_pct = 0; mismatches = 0;
      upper_len = 2400; lower_len = 1836; gear_ratio = 1707;
      shoulder_ofs = -175; elbow_ofs = 126; shoulder_lim = 9602; elbow_lim = 9920;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, reach bounds, negative y, limits, rest pose.
      send_target(14'sd0, 14'sd4236);
      send_target(14'sd4236, 14'sd0);
      send_target(-14'sd4236, 14'sd0);
      send_target(14'sd564, 14'sd0);
      send_target(14'sd563, 14'sd0);
      send_target(14'sd4237, 14'sd0);
      send_target(14'sd0, 14'sd3000);
      send_target(14'sd2000, 14'sd2500);
      send_target(-14'sd2000, 14'sd2500);
      send_target(14'sd1000, -14'sd1);
      send_target(14'sh2000, 14'sh2000);
      send_target(14'sd8191, 14'sd8191);
      send_target(14'sh2000, 14'sd8191);
      send_target(14'sd0, 14'sd0);
      send_target(-14'sd600, 14'sd100);
      end_burst();
      wait_drained();

      // Equal links: zero vector at the origin; tight limits; extreme offsets.
      write_all(1000, 1000, 4095, -2048, 2047, 0, 16383);
      send_target(14'sd0, 14'sd0);
      send_target(14'sd2000, 14'sd0);
      send_target(14'sd0, 14'sd1414);
      end_burst();
      wait_drained();
      write_all(4095, 4095, 256, 2047, -2048, 16383, 0);
      send_target(14'sd8190, 14'sd0);
      send_target(14'sd0, 14'sd5000);
      send_target(14'sd1, 14'sd0);
      end_burst();
      wait_drained();
      write_all(1, 4095, 1024, 0, 0, 16383, 16383);
      send_target(14'sd4095, 14'sd0);
      send_target(14'sd0, 14'sd4096);
      end_burst();
      wait_drained();

      // Random phases across settings and idling patterns.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_all(2400, 1836, 1707, -175, 126, 9602, 9920);
            1: write_all($urandom_range(4095, 1), $urandom_range(4095, 1),
                         $urandom_range(4095, 256), $urandom_range(4095, 0),
                         $urandom_range(4095, 0), 16383, 16383);
            2: write_all(3000, 2500, 1024, 100, -50, 12000, 12000);
            3: write_all($urandom_range(3000, 500), $urandom_range(3000, 500),
                         $urandom_range(4095, 256), $urandom_range(4095, 0),
                         $urandom_range(4095, 0), $urandom_range(16383, 0),
                         $urandom_range(16383, 0));
            4: write_all(2400, 1836, 4095, 2047, -2048, 16383, 16383);
            default: write_all(1500, 1500, 1707, -175, 126, 9602, 9920);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         for (int k = 0; k < 75; k++) begin
            // Hold off once until the result queue has fully drained.
            if (phase == 2 && k == 30) begin
               end_burst();
               while (board.pending.size() != 0) @(posedge clock);
            end
            send_random_target();
         end
         end_burst();
         send_idle_pct = 0; recv_stall_pct = 0;
         wait_drained();
      end

      if (mismatches == 0 && board.pending.size() == 0) begin
         $display("** two_link_arm_inverse_kinematics: PASSED **");
      end else begin
         $display("** two_link_arm_inverse_kinematics: FAILED **");
      end
      $finish;
   end
endmodule

[two_link_arm_inverse_kinematics.f]
sv/tlik_pkg.sv
sv/tlik_req_if.sv
sv/tlik_rsp_if.sv
sv/tlik_front.sv
sv/tlik_queue.sv
sv/tlik_back.sv
sv/two_link_arm_inverse_kinematics.sv
verif/testbench.sv
